### rtl/isasc_pkg.sv
// ----------------------------------------------------------------------------
// isasc_pkg
// Shared types and constants for the intake stall and sort controller.
// ----------------------------------------------------------------------------
package isasc_pkg;

    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    // register index, taken from paddr[4:2]
    typedef enum logic [2:0] {
        REG_OWN_COLOR   = 3'd0,
        REG_TORQUE_THR  = 3'd1,
        REG_STALL_TMO   = 3'd2,
        REG_SORT_HOLD   = 3'd3,
        REG_SORT_TOTAL  = 3'd4,
        REG_OUT_PULSE   = 3'd5,
        REG_PROX_MIN    = 3'd6,
        REG_UNUSED      = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        COLOR_NONE = 2'd0,
        COLOR_RED  = 2'd1,
        COLOR_BLUE = 2'd2,
        COLOR_BAD  = 2'd3
    } color_t;

    typedef enum logic [1:0] {
        CMD_NONE       = 2'd0,
        CMD_INTAKE_ON  = 2'd1,
        CMD_INTAKE_OFF = 2'd2,
        CMD_UNUSED     = 2'd3
    } intake_cmd_t;

    localparam logic [8:0] RED_LOW_HUE   = 9'd5;
    localparam logic [8:0] RED_HIGH_HUE  = 9'd350;
    localparam logic [8:0] BLUE_LOW_HUE  = 9'd200;
    localparam logic [8:0] BLUE_HIGH_HUE = 9'd230;

    localparam logic signed [14:0] FULL_MV     = 15'sd12000;
    localparam logic signed [14:0] NEG_FULL_MV = -15'sd12000;
    localparam logic signed [14:0] HALF_MV     = 15'sd6000;
    localparam logic signed [14:0] ZERO_MV     = 15'sd0;

    typedef struct packed {
        logic        own_color;
        logic [11:0] torque_threshold;
        logic [15:0] stall_timeout_ms;
        logic [15:0] sort_hold_ms;
        logic [15:0] sort_total_ms;
        logic [15:0] outtake_pulse_ms;
        logic [7:0]  proximity_min;
    } cfg_t;

    typedef struct packed {
        logic        arming;
        logic [31:0] arm_time;
        logic        stall_set;
    } watch_t;

    typedef struct packed {
        logic        busy;
        logic [31:0] begin_time;
        logic [31:0] last_time;
        color_t      seen;
    } sort_t;

endpackage

### rtl/intake_stall_and_sort_control.sv
// ----------------------------------------------------------------------------
// intake_stall_and_sort_control
// Intake motor anti-jam, color sort and driver control, one tick per item.
// ----------------------------------------------------------------------------
// Each input item is one control tick: time, both motor torques, color sensor
// hue and proximity, and the driver commands. Each item yields exactly one
// result item: both motor drive commands, the stall latches, the sort flag
// and the classified color. The user must write settings over the APB port
// only while no item is in flight; the block does not enforce this. pready is
// always high and reads return the settings. An accepted item lands in the
// input register; its result is loaded into the result register when that
// register is empty or being read, and out_valid rises with it. Throughput: one
// item per cycle while out_ready is high; the tick state (stall timers, sort
// hold, outtake pulse, intake enable) updates as the item moves from the input
// register to the result register, so the next item sees it.
// When out_ready is low the result holds, the input register holds one more
// item, and in_ready drops only when both are full.
// Reset clears all tick state, loads the default settings and empties both
// registers.
// ----------------------------------------------------------------------------
module intake_stall_and_sort_control (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [isasc_pkg::ADDR_W-1:0]  paddr,
    input  logic [isasc_pkg::DATA_W-1:0]  pwdata,
    output logic [isasc_pkg::DATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [31:0]                   now_ms,
    input  logic [11:0]                   front_torque,
    input  logic [11:0]                   back_torque,
    input  logic [8:0]                    hue,
    input  logic [7:0]                    proximity,
    input  logic                          toggle_pressed,
    input  logic                          eject_held,
    input  logic                          outtake_held,
    input  logic [1:0]                    intake_command,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [14:0]            front_drive_mv,
    output logic signed [14:0]            back_drive_mv,
    output logic                          front_stall_flag,
    output logic                          back_stall_flag,
    output logic                          sorting_active,
    output logic [1:0]                    seen_color
);

    isasc_pkg::cfg_t   cfg;
    isasc_pkg::watch_t front_w;
    isasc_pkg::watch_t back_w;
    isasc_pkg::sort_t  sort_r;

    // input register
    logic        item_valid_reg;
    logic        item_valid_next;
    logic [31:0] now_reg;
    logic [11:0] ft_reg;
    logic [11:0] bt_reg;
    logic [8:0]  hue_reg;
    logic [7:0]  prox_reg;
    logic        toggle_reg;
    logic        eject_reg;
    logic        outtake_reg;
    isasc_pkg::intake_cmd_t cmd_reg;

    // tick state
    logic        intake_on_reg,        intake_on_next;
    logic        front_arming_reg,     back_arming_reg;
    logic [31:0] front_arm_time_reg,   back_arm_time_reg;
    logic        front_stalled_reg,    front_stalled_next;
    logic        back_stalled_reg,     back_stalled_next;
    logic        sort_busy_reg;
    logic [31:0] sort_begin_reg,       sort_last_reg;
    logic        outtake_running_reg,  outtake_running_next;
    logic [31:0] outtake_begin_reg,    outtake_begin_next;

    // result register
    logic        out_valid_reg;
    logic        out_valid_next;
    logic signed [14:0] front_mv_reg, front_mv_next;
    logic signed [14:0] back_mv_reg,  back_mv_next;
    logic        front_flag_reg, back_flag_reg, sorting_reg;
    logic [1:0]  seen_reg;

    logic        advance;
    logic        fire;
    logic        accept;
    logic        cmd_clear;
    logic        fs_1, bs_1;
    logic        any_stall;
    logic        intake_1;
    logic [31:0] out_elapsed;

    isasc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    isasc_watch u_front_watch (
        .torque     (ft_reg),
        .now_ms     (now_reg),
        .threshold  (cfg.torque_threshold),
        .timeout_ms (cfg.stall_timeout_ms),
        .arming     (front_arming_reg),
        .arm_time   (front_arm_time_reg),
        .result     (front_w)
    );

    isasc_watch u_back_watch (
        .torque     (bt_reg),
        .now_ms     (now_reg),
        .threshold  (cfg.torque_threshold),
        .timeout_ms (cfg.stall_timeout_ms),
        .arming     (back_arming_reg),
        .arm_time   (back_arm_time_reg),
        .result     (back_w)
    );

    isasc_sort u_sort (
        .now_ms     (now_reg),
        .hue        (hue_reg),
        .proximity  (prox_reg),
        .cfg        (cfg),
        .busy       (sort_busy_reg),
        .begin_time (sort_begin_reg),
        .last_time  (sort_last_reg),
        .result     (sort_r)
    );

    // handshake
    assign advance         = !out_valid_reg || out_ready;
    assign in_ready        = !item_valid_reg || advance;
    assign accept          = in_valid && in_ready;
    assign fire            = item_valid_reg && advance;
    assign item_valid_next = accept || (item_valid_reg && !advance);
    assign out_valid_next  = advance ? item_valid_reg : out_valid_reg;

    // intake command, then stall latch, then toggle
    assign cmd_clear = (cmd_reg == isasc_pkg::CMD_INTAKE_ON)
                    || (cmd_reg == isasc_pkg::CMD_INTAKE_OFF);
    assign fs_1      = (front_stalled_reg && !cmd_clear) || front_w.stall_set;
    assign bs_1      = (back_stalled_reg && !cmd_clear) || back_w.stall_set;
    assign any_stall = fs_1 || bs_1;

    always_comb
    begin
        unique case (cmd_reg)
            isasc_pkg::CMD_INTAKE_ON:  intake_1 = 1'b1;
            isasc_pkg::CMD_INTAKE_OFF: intake_1 = 1'b0;
            default:                   intake_1 = intake_on_reg;
        endcase
    end

    // a run that starts on this tick has no time elapsed yet
    assign out_elapsed = outtake_running_reg ? (now_reg - outtake_begin_reg) : 32'd0;

    always_comb
    begin
        intake_on_next       = intake_1;
        front_stalled_next   = fs_1;
        back_stalled_next    = bs_1;
        outtake_running_next = outtake_running_reg;
        outtake_begin_next   = outtake_begin_reg;
        front_mv_next        = isasc_pkg::ZERO_MV;
        back_mv_next         = isasc_pkg::ZERO_MV;

        if (toggle_reg)
        begin
            if (any_stall)
            begin
                front_stalled_next = 1'b0;
                back_stalled_next  = 1'b0;
            end
            else
            begin
                intake_on_next = !intake_1;
            end
        end

        // sort wins, then eject, then outtake, then intake
        priority if (sort_r.busy)
        begin
            front_mv_next = isasc_pkg::HALF_MV;
            back_mv_next  = isasc_pkg::NEG_FULL_MV;
        end
        else if (eject_reg)
        begin
            front_stalled_next = 1'b0;
            back_stalled_next  = 1'b0;
            front_mv_next      = isasc_pkg::NEG_FULL_MV;
            back_mv_next       = isasc_pkg::NEG_FULL_MV;
        end
        else if (outtake_reg)
        begin
            front_stalled_next = 1'b0;
            back_stalled_next  = 1'b0;
            back_mv_next       = isasc_pkg::NEG_FULL_MV;
            if (!outtake_running_reg)
            begin
                outtake_begin_next   = now_reg;
                outtake_running_next = 1'b1;
            end
            front_mv_next = (out_elapsed < {16'd0, cfg.outtake_pulse_ms})
                          ? isasc_pkg::NEG_FULL_MV : isasc_pkg::ZERO_MV;
        end
        else if (intake_on_next)
        begin
            front_mv_next = front_stalled_next ? isasc_pkg::ZERO_MV : isasc_pkg::FULL_MV;
            back_mv_next  = back_stalled_next  ? isasc_pkg::ZERO_MV : isasc_pkg::FULL_MV;
        end
        else
        begin
            front_mv_next = isasc_pkg::ZERO_MV;
            back_mv_next  = isasc_pkg::ZERO_MV;
        end

        if (!outtake_reg)
            outtake_running_next = 1'b0;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg      <= 1'b0;
            out_valid_reg       <= 1'b0;
            intake_on_reg       <= 1'b0;
            front_arming_reg    <= 1'b0;
            back_arming_reg     <= 1'b0;
            front_arm_time_reg  <= '0;
            back_arm_time_reg   <= '0;
            front_stalled_reg   <= 1'b0;
            back_stalled_reg    <= 1'b0;
            sort_busy_reg       <= 1'b0;
            sort_begin_reg      <= '0;
            sort_last_reg       <= '0;
            outtake_running_reg <= 1'b0;
            outtake_begin_reg   <= '0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
            if (fire)
            begin
                intake_on_reg       <= intake_on_next;
                front_arming_reg    <= front_w.arming;
                back_arming_reg     <= back_w.arming;
                front_arm_time_reg  <= front_w.arm_time;
                back_arm_time_reg   <= back_w.arm_time;
                front_stalled_reg   <= front_stalled_next;
                back_stalled_reg    <= back_stalled_next;
                sort_busy_reg       <= sort_r.busy;
                sort_begin_reg      <= sort_r.begin_time;
                sort_last_reg       <= sort_r.last_time;
                outtake_running_reg <= outtake_running_next;
                outtake_begin_reg   <= outtake_begin_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            now_reg     <= now_ms;
            ft_reg      <= front_torque;
            bt_reg      <= back_torque;
            hue_reg     <= hue;
            prox_reg    <= proximity;
            toggle_reg  <= toggle_pressed;
            eject_reg   <= eject_held;
            outtake_reg <= outtake_held;
            cmd_reg     <= isasc_pkg::intake_cmd_t'(intake_command);
        end
        if (fire)
        begin
            front_mv_reg   <= front_mv_next;
            back_mv_reg    <= back_mv_next;
            front_flag_reg <= front_stalled_next;
            back_flag_reg  <= back_stalled_next;
            sorting_reg    <= sort_r.busy;
            seen_reg       <= sort_r.seen;
        end
    end

    assign out_valid        = out_valid_reg;
    assign front_drive_mv   = front_mv_reg;
    assign back_drive_mv    = back_mv_reg;
    assign front_stall_flag = front_flag_reg;
    assign back_stall_flag  = back_flag_reg;
    assign sorting_active   = sorting_reg;
    assign seen_color       = seen_reg;

endmodule

### rtl/isasc_cfg.sv
// ----------------------------------------------------------------------------
// isasc_cfg
// APB register file holding the controller settings.
// ----------------------------------------------------------------------------
module isasc_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [isasc_pkg::ADDR_W-1:0]  paddr,
    input  logic [isasc_pkg::DATA_W-1:0]  pwdata,
    output logic [isasc_pkg::DATA_W-1:0]  prdata,
    output logic                          pready,
    output isasc_pkg::cfg_t               cfg
);

    isasc_pkg::cfg_t      cfg_reg;
    isasc_pkg::cfg_t      cfg_next;
    isasc_pkg::reg_idx_t  idx;
    logic                 wr_en;

    assign idx    = isasc_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                isasc_pkg::REG_OWN_COLOR:  cfg_next.own_color        = pwdata[0];
                isasc_pkg::REG_TORQUE_THR: cfg_next.torque_threshold = pwdata[11:0];
                isasc_pkg::REG_STALL_TMO:  cfg_next.stall_timeout_ms = pwdata[15:0];
                isasc_pkg::REG_SORT_HOLD:  cfg_next.sort_hold_ms     = pwdata[15:0];
                isasc_pkg::REG_SORT_TOTAL: cfg_next.sort_total_ms    = pwdata[15:0];
                isasc_pkg::REG_OUT_PULSE:  cfg_next.outtake_pulse_ms = pwdata[15:0];
                isasc_pkg::REG_PROX_MIN:   cfg_next.proximity_min    = pwdata[7:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            isasc_pkg::REG_OWN_COLOR:  prdata = {31'd0, cfg_reg.own_color};
            isasc_pkg::REG_TORQUE_THR: prdata = {20'd0, cfg_reg.torque_threshold};
            isasc_pkg::REG_STALL_TMO:  prdata = {16'd0, cfg_reg.stall_timeout_ms};
            isasc_pkg::REG_SORT_HOLD:  prdata = {16'd0, cfg_reg.sort_hold_ms};
            isasc_pkg::REG_SORT_TOTAL: prdata = {16'd0, cfg_reg.sort_total_ms};
            isasc_pkg::REG_OUT_PULSE:  prdata = {16'd0, cfg_reg.outtake_pulse_ms};
            isasc_pkg::REG_PROX_MIN:   prdata = {24'd0, cfg_reg.proximity_min};
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_color        <= 1'b0;
            cfg_reg.torque_threshold <= 12'd270;
            cfg_reg.stall_timeout_ms <= 16'd500;
            cfg_reg.sort_hold_ms     <= 16'd175;
            cfg_reg.sort_total_ms    <= 16'd400;
            cfg_reg.outtake_pulse_ms <= 16'd100;
            cfg_reg.proximity_min    <= 8'd90;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### rtl/isasc_watch.sv
// ----------------------------------------------------------------------------
// isasc_watch
// Per-motor stall watch: arm above threshold, disarm below 9/10, time out.
// ----------------------------------------------------------------------------
module isasc_watch (
    input  logic [11:0]          torque,
    input  logic [31:0]          now_ms,
    input  logic [11:0]          threshold,
    input  logic [15:0]          timeout_ms,
    input  logic                 arming,
    input  logic [31:0]          arm_time,
    output isasc_pkg::watch_t    result
);

    logic        start;
    logic        armed;
    logic [31:0] arm_t;
    logic [15:0] torque_x10;
    logic [15:0] thr_x9;
    logic        below;
    logic [31:0] elapsed;

    assign start      = !arming && (torque > threshold);
    assign armed      = arming || start;
    assign arm_t      = start ? now_ms : arm_time;
    // exact 9/10 compare: 10*torque < 9*threshold
    assign torque_x10 = {torque, 3'b000} + {3'b000, torque, 1'b0};
    assign thr_x9     = {1'b0, threshold, 3'b000} + {4'd0, threshold};
    assign below      = torque_x10 < thr_x9;
    assign elapsed    = now_ms - arm_t;

    always_comb
    begin
        result.arm_time  = arm_t;
        result.arming    = armed && !below;
        result.stall_set = result.arming && (elapsed > {16'd0, timeout_ms});
    end

endmodule

### rtl/isasc_sort.sv
// ----------------------------------------------------------------------------
// isasc_sort
// Color classification and wrong-color sort hold timing.
// ----------------------------------------------------------------------------
module isasc_sort (
    input  logic [31:0]        now_ms,
    input  logic [8:0]         hue,
    input  logic [7:0]         proximity,
    input  isasc_pkg::cfg_t    cfg,
    input  logic               busy,
    input  logic [31:0]        begin_time,
    input  logic [31:0]        last_time,
    output isasc_pkg::sort_t   result
);

    isasc_pkg::color_t seen;
    logic              wrong;
    logic              busy_1;
    logic [31:0]       begin_1;
    logic [31:0]       last_1;
    logic [31:0]       since_last;
    logic [31:0]       since_begin;

    always_comb
    begin
        seen = isasc_pkg::COLOR_NONE;
        if (proximity > cfg.proximity_min)
        begin
            priority if (hue < isasc_pkg::RED_LOW_HUE || hue > isasc_pkg::RED_HIGH_HUE)
                seen = isasc_pkg::COLOR_RED;
            else if (hue > isasc_pkg::BLUE_LOW_HUE && hue < isasc_pkg::BLUE_HIGH_HUE)
                seen = isasc_pkg::COLOR_BLUE;
            else
                seen = isasc_pkg::COLOR_NONE;
        end
    end

    assign wrong = (seen == isasc_pkg::COLOR_RED && cfg.own_color)
                || (seen == isasc_pkg::COLOR_BLUE && !cfg.own_color);

    assign busy_1      = busy || wrong;
    assign begin_1     = (wrong && !busy) ? now_ms : begin_time;
    assign last_1      = wrong ? now_ms : last_time;
    assign since_last  = now_ms - last_1;
    assign since_begin = now_ms - begin_1;

    always_comb
    begin
        result.seen       = seen;
        result.begin_time = begin_1;
        result.last_time  = last_1;
        // end the hold once both the hold and the total time have run out
        result.busy       = busy_1 && !((since_last > {16'd0, cfg.sort_hold_ms})
                                     && (since_begin > {16'd0, cfg.sort_total_ms}));
    end

endmodule
